### sv/crts_pkg.sv
// ----------------------------------------------------------------------------
// crts_pkg: shared types and constants of the range translator
// Field widths, request and register codes, and the queued request format.
// ----------------------------------------------------------------------------
package crts_pkg;

   localparam int CP_W  = 21;  // code point width
   localparam int CNT_W = 5;   // width of the count registers
   localparam int POS_W = 27;  // position in concatenated ranges: 31 ranges of 2**21

   // One past the last code point; marks an empty squeeze memory.
   localparam logic [CP_W-1:0] NO_CHAR = 21'd1114112;

   // Request type codes on the input channel.
   localparam logic [1:0] REQ_XLATE  = 2'd0;
   localparam logic [1:0] REQ_WR_SRC = 2'd1;
   localparam logic [1:0] REQ_WR_TGT = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_SQUEEZE    = 2'd0;
   localparam logic [1:0] REG_COMPLEMENT = 2'd1;
   localparam logic [1:0] REG_SRC_COUNT  = 2'd2;
   localparam logic [1:0] REG_TGT_COUNT  = 2'd3;

   typedef enum logic [1:0] {
      OP_XLATE,
      OP_WR_SRC,
      OP_WR_TGT
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [3:0]      entry_index;
      logic [CP_W-1:0] range_low;
      logic [CP_W-1:0] range_high;
      logic [CP_W-1:0] code_point;
      logic            string_start;
   } item_type;

   typedef struct packed {
      logic             squeeze_mode;
      logic             complement_mode;
      logic [CNT_W-1:0] source_count;
      logic [CNT_W-1:0] target_count;
   } cfg_type;

endpackage

### sv/crts_front.sv
// ----------------------------------------------------------------------------
// crts_front: request intake
// Decodes the request type, drops unused codes and pushes the rest to the queue.
// ----------------------------------------------------------------------------
module crts_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic [3:0]                 req_entry_index,
   input  logic [crts_pkg::CP_W-1:0]  req_range_low,
   input  logic [crts_pkg::CP_W-1:0]  req_range_high,
   input  logic [crts_pkg::CP_W-1:0]  req_code_point,
   input  logic                       req_string_start,
   input  logic                       q_full,
   output logic                       q_push,
   output crts_pkg::item_type         q_item
);

   logic keep;

   always_comb begin
      keep      = 1'b1;
      q_item.op = crts_pkg::OP_XLATE;
      unique case (req_type)
         crts_pkg::REQ_XLATE:  q_item.op = crts_pkg::OP_XLATE;
         crts_pkg::REQ_WR_SRC: q_item.op = crts_pkg::OP_WR_SRC;
         crts_pkg::REQ_WR_TGT: q_item.op = crts_pkg::OP_WR_TGT;
         default:              keep      = 1'b0;
      endcase
      q_item.entry_index  = req_entry_index;
      q_item.range_low    = req_range_low;
      q_item.range_high   = req_range_high;
      q_item.code_point   = req_code_point;
      q_item.string_start = req_string_start;
   end

   // An unused code is taken and dropped, so it only waits for queue space.
   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full & keep;

endmodule

### sv/crts_queue.sv
// ----------------------------------------------------------------------------
// crts_queue: two-entry request queue
// Decouples request intake from the table search sequencer.
// ----------------------------------------------------------------------------
module crts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crts_pkg::item_type push_item,
   input  logic               pop,
   output crts_pkg::item_type head,
   output logic               full,
   output logic               empty
);

   crts_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);

endmodule

### sv/crts_back.sv
// ----------------------------------------------------------------------------
// crts_back: table store and search sequencer
// Holds both range tables, walks them one entry at a time with a read state and an
// evaluate state per entry, applies the squeeze rule and presents results through an output register.
// ----------------------------------------------------------------------------
module crts_back #(
   parameter int RANGE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  crts_pkg::cfg_type          cfg,
   input  crts_pkg::item_type         head,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [crts_pkg::CP_W-1:0]  rsp_out_code_point,
   output logic                       rsp_changed
);

   localparam int IDX_W = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
   localparam int CW    = (IDX_W + 1 > crts_pkg::CNT_W) ? IDX_W + 1 : crts_pkg::CNT_W;
   localparam int CP_W  = crts_pkg::CP_W;
   localparam int POS_W = crts_pkg::POS_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SRD    = 8'b0000_0010,
      S_SEVAL  = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_TRD    = 8'b0001_0000,
      S_TEVAL  = 8'b0010_0000,
      S_SQ     = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [2*CP_W-1:0] src_mem [RANGE_ENTRIES];
   logic [2*CP_W-1:0] tgt_mem [RANGE_ENTRIES];
   logic [2*CP_W-1:0] src_rd_ff, tgt_rd_ff;

   logic [CW-1:0]    ctr_ff, ctr_in;
   logic             found_ff, found_in;
   logic             last_only_ff, last_only_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] seen_ff, seen_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic [CP_W-1:0]  res_ff, res_in;
   logic [CP_W-1:0]  prev_ff, prev_in;
   logic             prev_valid_ff, prev_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]  rsp_cp_ff, rsp_cp_in;
   logic             rsp_chg_ff, rsp_chg_in;

   logic [CW-1:0]    src_n, tgt_n;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_ok, src_we, tgt_we;
   logic [CP_W-1:0]  e_lo, e_hi;
   logic [CP_W:0]    e_size;
   logic [POS_W-1:0] seen_next;
   logic             out_free;

   // Counts saturate at the table depth; a target count of zero acts as one.
   always_comb begin
      if (int'(cfg.source_count) > RANGE_ENTRIES) src_n = CW'(RANGE_ENTRIES);
      else                                        src_n = CW'(cfg.source_count);
      if (int'(cfg.target_count) > RANGE_ENTRIES) tgt_n = CW'(RANGE_ENTRIES);
      else if (cfg.target_count == '0)            tgt_n = CW'(1);
      else                                        tgt_n = CW'(cfg.target_count);
   end

   assign rd_addr = ctr_ff[IDX_W-1:0];
   assign wr_addr = IDX_W'(head.entry_index);
   assign wr_ok   = int'(head.entry_index) < RANGE_ENTRIES;
   assign q_pop   = state_ff[0] & ~q_empty;
   assign src_we  = q_pop & (head.op == crts_pkg::OP_WR_SRC) & wr_ok;
   assign tgt_we  = q_pop & (head.op == crts_pkg::OP_WR_TGT) & wr_ok;

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[wr_addr] <= {head.range_low, head.range_high};
      end
      src_rd_ff <= src_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[wr_addr] <= {head.range_low, head.range_high};
      end
      tgt_rd_ff <= tgt_mem[rd_addr];
   end

   // The entry under evaluation comes from whichever table is being walked.
   always_comb begin
      if (state_ff == S_SEVAL) {e_lo, e_hi} = src_rd_ff;
      else                     {e_lo, e_hi} = tgt_rd_ff;
      if (e_lo > e_hi) e_size = '0;
      else             e_size = {1'b0, e_hi} - {1'b0, e_lo} + (CP_W+1)'(1);
      seen_next = seen_ff + POS_W'(e_size);
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      ctr_in        = ctr_ff;
      found_in      = found_ff;
      last_only_in  = last_only_ff;
      pos_in        = pos_ff;
      seen_in       = seen_ff;
      cp_in         = cp_ff;
      res_in        = res_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_cp_in     = rsp_cp_ff;
      rsp_chg_in    = rsp_chg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (~q_empty && head.op == crts_pkg::OP_XLATE) begin
               cp_in    = head.code_point;
               ctr_in   = '0;
               seen_in  = '0;
               found_in = 1'b0;
               if (head.string_start) prev_valid_in = 1'b0;
               state_in = (src_n == '0) ? S_DECIDE : S_SRD;
            end
         end
         S_SRD: state_in = S_SEVAL;
         S_SEVAL: begin
            // Later entries override earlier ones, so the last hit wins.
            if (e_lo <= cp_ff && cp_ff <= e_hi) begin
               found_in = 1'b1;
               pos_in   = seen_ff + POS_W'(cp_ff - e_lo);
            end
            seen_in = seen_next;
            ctr_in  = ctr_ff + CW'(1);
            if (ctr_ff + CW'(1) == src_n) state_in = S_DECIDE;
            else                         state_in = S_SRD;
         end
         S_DECIDE: begin
            seen_in = '0;
            if (cfg.complement_mode == found_ff) begin
               // Not a member: pass through and forget the squeeze history.
               res_in        = cp_ff;
               prev_valid_in = 1'b0;
               prev_in       = crts_pkg::NO_CHAR;
               state_in      = S_OUT;
            end else begin
               last_only_in = cfg.complement_mode;
               ctr_in       = cfg.complement_mode ? tgt_n - CW'(1) : '0;
               state_in     = S_TRD;
            end
         end
         S_TRD: state_in = S_TEVAL;
         S_TEVAL: begin
            if (~last_only_ff && seen_next > pos_ff) begin
               res_in   = e_lo + CP_W'(pos_ff - seen_ff);
               state_in = S_SQ;
            end else if (last_only_ff || ctr_ff + CW'(1) == tgt_n) begin
               res_in   = e_hi;
               state_in = S_SQ;
            end else begin
               seen_in  = seen_next;
               ctr_in   = ctr_ff + CW'(1);
               state_in = S_TRD;
            end
         end
         S_SQ: begin
            if (cfg.squeeze_mode && prev_valid_ff && prev_ff == res_ff) begin
               state_in = S_IDLE;
            end else begin
               prev_in       = res_ff;
               prev_valid_in = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cp_in    = res_ff;
               rsp_chg_in   = (res_ff != cp_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_valid_ff <= 1'b0;
         prev_ff       <= crts_pkg::NO_CHAR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_valid_ff <= prev_valid_in;
         prev_ff       <= prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ctr_ff       <= ctr_in;
      found_ff     <= found_in;
      last_only_ff <= last_only_in;
      pos_ff       <= pos_in;
      seen_ff      <= seen_in;
      cp_ff        <= cp_in;
      res_ff       <= res_in;
      rsp_cp_ff    <= rsp_cp_in;
      rsp_chg_ff   <= rsp_chg_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_code_point = rsp_cp_ff;
   assign rsp_changed        = rsp_chg_ff;

endmodule

### sv/char_range_translate_squeeze.sv
// Operation: a range write is done when the sequencer takes it from the queue. A translate
// beat walks all S source entries, S being the source count, and for a translated
// character then the target entries up to the one holding its position (only the last
// one in complement mode); each table entry takes a read state and an evaluate state.
// Throughput is one beat at a time in the sequencer; a two-entry queue and the output
// register keep both channels moving. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
// char_range_translate_squeeze: tr-style code point translation with squeeze
// Translates code points through loaded source and target range tables, with
// complement and squeeze modes set over a small register port.
// ----------------------------------------------------------------------------
module char_range_translate_squeeze #(
   parameter int RANGE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration register writes.
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [crts_pkg::CNT_W-1:0] csr_write_data,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic [3:0]                 req_entry_index,
   input  logic [crts_pkg::CP_W-1:0]  req_range_low,
   input  logic [crts_pkg::CP_W-1:0]  req_range_high,
   input  logic [crts_pkg::CP_W-1:0]  req_code_point,
   input  logic                       req_string_start,
   // Result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [crts_pkg::CP_W-1:0]  rsp_out_code_point,
   output logic                       rsp_changed
);

   // The register block holds the mode bits and the raw counts. Counts are
   // clamped where they are used, so the registers keep what was written.
   crts_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            crts_pkg::REG_SQUEEZE:    cfg_in.squeeze_mode    = csr_write_data[0];
            crts_pkg::REG_COMPLEMENT: cfg_in.complement_mode = csr_write_data[0];
            crts_pkg::REG_SRC_COUNT:  cfg_in.source_count    = csr_write_data;
            crts_pkg::REG_TGT_COUNT:  cfg_in.target_count    = csr_write_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.squeeze_mode    <= 1'b0;
         cfg_ff.complement_mode <= 1'b0;
         cfg_ff.source_count    <= '0;
         cfg_ff.target_count    <= crts_pkg::CNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes each beat and hands it to the queue. Unused request
   // codes are accepted and dropped there, so they never reach the sequencer.
   crts_pkg::item_type push_item, head_item;
   logic q_push, q_pop, q_full, q_empty;

   crts_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .req_code_point   (req_code_point),
      .req_string_start (req_string_start),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   crts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns both tables. Range writes and translations are taken
   // from the queue in order, so a translation always sees earlier writes.
   crts_back #(
      .RANGE_ENTRIES (RANGE_ENTRIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head               (head_item),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_code_point (rsp_out_code_point),
      .rsp_changed        (rsp_changed)
   );

   // The sequencer must never take a beat from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // A useful beat accepted at the input must be held in the queue afterwards.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == crts_pkg::REQ_XLATE ||
       req_type == crts_pkg::REQ_WR_SRC || req_type == crts_pkg::REQ_WR_TGT))
      |=> !q_empty)
      else $error("accepted beat missing from queue");

   // The input side stalls only when the queue is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_full)
      else $error("input stalled with queue space");

endmodule
